// File: src/crcdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer package
// Shared types, codes and the CRC byte update for the deframer and its checker.
// ----------------------------------------------------------------------------
package crcdf_pkg;

	localparam logic [7:0]  START_RESET = 8'hAA;
	localparam logic [7:0]  MAXLEN_RESET = 8'hFF;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic CFG_START_BYTE = 1'b0;
	localparam logic CFG_MAX_LENGTH = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_LEN_LO  = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC_LO  = 3'd4,
		PH_CRC_HI  = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_START  = 3'd1,
		ST_LENGTH = 3'd2,
		ST_CRC    = 3'd3,
		ST_TRUNC  = 3'd4
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic [7:0] len;
		status_t    status;
		logic       last;
	} result_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: src/crc16_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer
// Parses length-prefixed frames with a CRC-16/Modbus trailer, one byte per item,
// and emits data bytes and one status item per burst.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | rx_byte, burst_end
//  out     | output    | out_valid/ out_ready | item_kind, data_byte, command_code,
//          |           |                      | payload_length, frame_status, is_last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
//  One input item is taken per cycle while in_ready is high; its results are in the output queue the next cycle.
//  An item yields up to two results, which leave the four-entry queue one per cycle while out_ready is high.
//  in_ready falls while fewer than two queue slots are free.
//  Reset loads start byte 0xAA and max length 255 and waits for a start byte.
// ----------------------------------------------------------------------------
module crc16_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        burst_end,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  command_code,
	output logic [7:0]  payload_length,
	output logic [2:0]  frame_status,
	output logic        is_last
);

	logic [7:0] start_byte_q, max_length_q;

	crcdf_pkg::phase_t phase_q, phase_nxt;
	logic [7:0]  count_q, count_nxt;
	logic [15:0] flen_q, flen_nxt;
	logic [15:0] crc_q, crc_nxt;
	logic [7:0]  crc_lo_q, crc_lo_nxt;
	logic [7:0]  cmd_q, cmd_nxt;
	logic        sent_q, sent_nxt;

	crcdf_pkg::result_t q_mem [crcdf_pkg::QDEPTH];
	logic [crcdf_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [crcdf_pkg::QPTR_W:0]   fill_q;

	crcdf_pkg::result_t item0, item1, sts_item, dat_item;
	logic [1:0] push_n;
	logic       take, pop, has_data, has_status;
	crcdf_pkg::status_t st_code;
	logic [7:0]  count_inc;
	logic [15:0] crc_rx;

	assign take = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign in_ready = (fill_q <= (crcdf_pkg::QPTR_W+1)'(crcdf_pkg::QDEPTH - 2));
	assign out_valid = (fill_q != '0);
	assign count_inc = count_q + 8'd1;
	assign crc_rx = {rx_byte, crc_lo_q};

	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		flen_nxt = flen_q;
		crc_nxt = crc_q;
		crc_lo_nxt = crc_lo_q;
		cmd_nxt = cmd_q;
		sent_nxt = sent_q;
		has_data = 1'b0;
		has_status = 1'b0;
		st_code = crcdf_pkg::ST_OK;

		case (phase_q)
			crcdf_pkg::PH_START: begin
				if (rx_byte == start_byte_q) begin
					phase_nxt = crcdf_pkg::PH_LEN_LO;
				end else begin
					has_status = 1'b1;
					st_code = crcdf_pkg::ST_START;
				end
			end
			crcdf_pkg::PH_LEN_LO: begin
				flen_nxt = {8'h00, rx_byte};
				phase_nxt = crcdf_pkg::PH_LEN_HI;
			end
			crcdf_pkg::PH_LEN_HI: begin
				flen_nxt = {rx_byte, flen_q[7:0]};
				if (flen_nxt == 16'h0000 || flen_nxt > {8'h00, max_length_q}) begin
					has_status = 1'b1;
					st_code = crcdf_pkg::ST_LENGTH;
				end else begin
					count_nxt = 8'd0;
					phase_nxt = crcdf_pkg::PH_PAYLOAD;
				end
			end
			crcdf_pkg::PH_PAYLOAD: begin
				crc_nxt = crcdf_pkg::crc_update(crc_q, rx_byte);
				if (count_q == 8'd0) begin
					cmd_nxt = rx_byte;
				end else begin
					has_data = 1'b1;
				end
				count_nxt = count_inc;
				if ({8'h00, count_inc} >= flen_q) begin
					phase_nxt = crcdf_pkg::PH_CRC_LO;
				end
			end
			crcdf_pkg::PH_CRC_LO: begin
				crc_lo_nxt = rx_byte;
				phase_nxt = crcdf_pkg::PH_CRC_HI;
			end
			crcdf_pkg::PH_CRC_HI: begin
				has_status = 1'b1;
				st_code = (crc_rx == crc_q) ? crcdf_pkg::ST_OK : crcdf_pkg::ST_CRC;
			end
			default: begin
			end
		endcase

		if (has_status) begin
			sent_nxt = 1'b1;
			phase_nxt = crcdf_pkg::PH_SKIP;
		end
		if (burst_end && !sent_nxt) begin
			has_status = 1'b1;
			st_code = crcdf_pkg::ST_TRUNC;
		end

		dat_item = '{kind: crcdf_pkg::KIND_DATA, data: rx_byte, cmd: 8'h00, len: 8'h00,
			status: crcdf_pkg::ST_OK, last: 1'b0};
		sts_item = '{kind: crcdf_pkg::KIND_STATUS, data: 8'h00, cmd: cmd_nxt,
			len: flen_nxt[7:0], status: st_code, last: 1'b1};

		item0 = has_data ? dat_item : sts_item;
		item1 = sts_item;
		push_n = take ? ({1'b0, has_data} + {1'b0, has_status}) : 2'd0;

		if (burst_end) begin
			phase_nxt = crcdf_pkg::PH_START;
			count_nxt = 8'd0;
			flen_nxt = 16'h0000;
			crc_nxt = crcdf_pkg::CRC_INIT;
			crc_lo_nxt = 8'd0;
			cmd_nxt = 8'd0;
			sent_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= crcdf_pkg::START_RESET;
			max_length_q <= crcdf_pkg::MAXLEN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == crcdf_pkg::CFG_START_BYTE) begin
				start_byte_q <= cfg_data;
			end else begin
				max_length_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crcdf_pkg::PH_START;
			count_q <= 8'd0;
			flen_q <= 16'h0000;
			crc_q <= crcdf_pkg::CRC_INIT;
			crc_lo_q <= 8'd0;
			cmd_q <= 8'd0;
			sent_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			flen_q <= flen_nxt;
			crc_q <= crc_nxt;
			crc_lo_q <= crc_lo_nxt;
			cmd_q <= cmd_nxt;
			sent_q <= sent_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= item0;
		end
		if (push_n == 2'd2) begin
			q_mem[wr_ptr_q + crcdf_pkg::QPTR_W'(1)] <= item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + crcdf_pkg::QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + crcdf_pkg::QPTR_W'(1);
			end
			fill_q <= fill_q + (crcdf_pkg::QPTR_W+1)'(push_n)
				- (crcdf_pkg::QPTR_W+1)'(pop);
		end
	end

	assign item_kind = q_mem[rd_ptr_q].kind;
	assign data_byte = q_mem[rd_ptr_q].data;
	assign command_code = q_mem[rd_ptr_q].cmd;
	assign payload_length = q_mem[rd_ptr_q].len;
	assign frame_status = q_mem[rd_ptr_q].status;
	assign is_last = q_mem[rd_ptr_q].last;

endmodule

// File: src/crcdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 frame deframer port properties
// Port-level properties of the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module crcdf_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        item_kind,
	input logic [7:0]  data_byte,
	input logic [7:0]  command_code,
	input logic [7:0]  payload_length,
	input logic [2:0]  frame_status,
	input logic        is_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the item was taken");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status <= 3'(crcdf_pkg::ST_TRUNC))
		else $error("frame_status out of range");

	a_data_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == crcdf_pkg::KIND_DATA |->
			!is_last && frame_status == 3'd0 && command_code == 8'd0
			&& payload_length == 8'd0)
		else $error("data item carries status fields");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == crcdf_pkg::KIND_STATUS |-> is_last && data_byte == 8'd0)
		else $error("status item malformed");

endmodule

bind crc16_frame_deframer crcdf_port_props u_crcdf_port_props (.*);
